// ===== rtl/vas_pkg.sv =====
// ----------------------------------------------------------------------------
// vas_pkg
// Shared types and constants of the voice allocator with reserved stealing.
// ----------------------------------------------------------------------------
package vas_pkg;

   // table geometry
   localparam int NUM_VOICES = 24;
   localparam int NUM_PARTS  = 4;
   localparam int NUM_REGS   = 4;

   // derived widths
   localparam int IDX_W  = $clog2(NUM_VOICES);
   localparam int CNT_W  = $clog2(NUM_VOICES + 1);
   localparam int PART_W = 2;
   localparam int REQ_PART_W = 3;
   localparam int RES_W  = 5;
   localparam int CMP_W  = (CNT_W > RES_W) ? CNT_W : RES_W;
   localparam int KEY_W  = 32;
   localparam int AGE_W  = 32;
   localparam int VOICE_W = 5;
   localparam int PCNT_W  = 5;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_SEL_LO = 2;
   localparam logic [RES_W-1:0] RES_RESET = RES_W'(3);

   typedef enum logic {
      OP_NOTE_ON  = 1'b0,
      OP_NOTE_OFF = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // one entry of the voice table memory
   typedef struct packed {
      logic [PART_W-1:0] part;
      logic [KEY_W-1:0]  key;
      logic [AGE_W-1:0]  age;
   } voice_entry_type;

   typedef logic [NUM_PARTS-1:0][CNT_W-1:0] count_vec_type;
   typedef logic [NUM_REGS-1:0][RES_W-1:0]  res_vec_type;

   // victim part plan handed to the scan
   typedef struct packed {
      logic              from_other;
      logic [PART_W-1:0] target_part;
   } victim_plan_type;

endpackage

// ===== rtl/vas_victim_select.sv =====
// ----------------------------------------------------------------------------
// vas_victim_select
// Picks the part whose oldest voice is stolen when the table is full.
// ----------------------------------------------------------------------------
module vas_victim_select
   import vas_pkg::*;
(
   input  logic [PART_W-1:0] part,
   input  count_vec_type     counts,
   input  res_vec_type       reservations,
   output victim_plan_type   plan
);

   logic [CMP_W-1:0]  own_cnt;
   logic [CMP_W-1:0]  own_res;
   logic [CMP_W-1:0]  q_cnt;
   logic [CMP_W-1:0]  q_res;
   logic [CMP_W-1:0]  q_over;
   logic [CMP_W-1:0]  top_excess;
   logic [PART_W-1:0] best_part;
   logic              best_hit;

   // own part over its reservation wins, then the most over other part
   always_comb begin
      own_cnt    = CMP_W'(counts[part]);
      own_res    = CMP_W'(reservations[part]);
      top_excess = '0;
      best_part  = part;
      best_hit   = 1'b0;
      for (int q = 0; q < NUM_PARTS; q++) begin
         q_cnt  = CMP_W'(counts[q]);
         q_res  = CMP_W'(reservations[q]);
         q_over = q_cnt - q_res;
         if ((PART_W'(q) != part) && (q_cnt > q_res) && (q_over > top_excess)) begin
            top_excess = q_over;
            best_part  = PART_W'(q);
            best_hit   = 1'b1;
         end
      end
      if (own_cnt > own_res) begin
         plan.from_other  = 1'b0;
         plan.target_part = part;
      end else if (best_hit) begin
         plan.from_other  = 1'b1;
         plan.target_part = best_part;
      end else begin
         plan.from_other  = 1'b0;
         plan.target_part = part;
      end
   end

endmodule

// ===== rtl/voice_allocator_reserved_stealing.sv =====
// ----------------------------------------------------------------------------
// voice_allocator_reserved_stealing
// Polyphonic voice allocator with per-part reservations and voice stealing.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one note event per beat: opcode (note on / note off),
//   part and a 32-bit note key. rsp channel returns one beat per event:
//   found, voice, stolen and the part's active voice count after the event.
//   csr port holds the four 5-bit part reservations at byte offsets 0,4,8,12;
//   write them only while no event is in flight.
// Event sequence:
//   an event passes through an accept state, a scan that reads the voice table
//   memory one entry per cycle behind a registered read port, and a write-back
//   state that holds while the output register is still full. A new event is
//   accepted only once the last one is written back; an invalid part skips the scan.
// Reset:
//   all voices inactive, counts and age serial zero, reservations 3. No
//   clearing pass; table entries are read only behind their active flags.
// Back-pressure:
//   the result sits in an output register; the next event is accepted while
//   it waits, and that event's write-back holds until the register frees.
// ----------------------------------------------------------------------------
module voice_allocator_reserved_stealing
   import vas_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [REQ_PART_W-1:0] req_part,
   input  logic [KEY_W-1:0]      req_note_key,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic [VOICE_W-1:0]    rsp_voice,
   output logic                  rsp_stolen,
   output logic [PCNT_W-1:0]     rsp_part_count,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // control and event registers
   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [PART_W-1:0]    part_ff, part_in;
   logic                 part_ok_ff, part_ok_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   victim_plan_type      plan_ff, plan_in;
   victim_plan_type      plan_now;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // scan trackers
   logic                 free_hit_ff, free_hit_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic                 vic_hit_ff, vic_hit_in;
   logic [IDX_W-1:0]     vic_idx_ff, vic_idx_in;
   logic [AGE_W-1:0]     vic_age_ff, vic_age_in;
   logic                 match_hit_ff, match_hit_in;
   logic [IDX_W-1:0]     match_idx_ff, match_idx_in;

   // table state outside the memory
   logic [NUM_VOICES-1:0] active_ff, active_in;
   count_vec_type         counts_ff, counts_in;
   logic [AGE_W-1:0]      age_ff, age_in;
   res_vec_type           res_ff;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [VOICE_W-1:0]   rsp_voice_ff, rsp_voice_in;
   logic                 rsp_stolen_ff, rsp_stolen_in;
   logic [PCNT_W-1:0]    rsp_pcnt_ff, rsp_pcnt_in;

   // voice table memory
   voice_entry_type      mem [NUM_VOICES];
   voice_entry_type      rd_entry_ff;
   voice_entry_type      wr_entry;
   logic                 mem_re, mem_we;
   logic [IDX_W-1:0]     mem_raddr;
   logic [IDX_W-1:0]     wr_idx;

   // misc control
   logic                 eval_en;
   logic [IDX_W-1:0]     eval_idx;
   logic                 eval_act;
   logic                 commit;
   logic                 take_free, take_vic, take_off;
   logic [REG_SEL_LO-1+$clog2(NUM_REGS):REG_SEL_LO] unused_sel;
   logic [$clog2(NUM_REGS)-1:0] reg_sel;
   logic                 csr_wr;

   // victim part is planned from counts at accept time
   vas_victim_select u_victim (
      .part         (req_part[PART_W-1:0]),
      .counts       (counts_ff),
      .reservations (res_ff),
      .plan         (plan_now)
   );

   // configuration registers
   assign unused_sel = csr_paddr[REG_SEL_LO-1+$clog2(NUM_REGS):REG_SEL_LO];
   assign reg_sel    = unused_sel;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = CSR_DATA_W'(res_ff[reg_sel]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            res_ff[r] <= RES_RESET;
         end
      end else if (csr_wr) begin
         res_ff[reg_sel] <= csr_pwdata[RES_W-1:0];
      end
   end

   // memory read and write ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= wr_entry;
      end
      if (mem_re) begin
         rd_entry_ff <= mem[mem_raddr];
      end
   end

   // scan addressing: entry cnt-1 is evaluated while cnt is read
   assign mem_re    = (state_ff == ST_SCAN) && (cnt_ff < CNT_W'(NUM_VOICES));
   assign mem_raddr = cnt_ff[IDX_W-1:0];
   assign eval_en   = (state_ff == ST_SCAN) && (cnt_ff != '0);
   assign eval_idx  = IDX_W'(cnt_ff - CNT_W'(1));
   assign eval_act  = active_ff[eval_idx];

   // write-back decisions
   assign commit    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign take_free = part_ok_ff && (op_ff == OP_NOTE_ON) && free_hit_ff;
   assign take_vic  = part_ok_ff && (op_ff == OP_NOTE_ON) && !free_hit_ff && vic_hit_ff;
   assign take_off  = part_ok_ff && (op_ff == OP_NOTE_OFF) && match_hit_ff;
   assign wr_idx    = free_hit_ff ? free_idx_ff : vic_idx_ff;
   assign mem_we    = commit && (take_free || take_vic);
   assign wr_entry  = '{part: part_ff, key: key_ff, age: age_ff};
   assign req_ready = (state_ff == ST_IDLE);

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      part_in       = part_ff;
      part_ok_in    = part_ok_ff;
      key_in        = key_ff;
      plan_in       = plan_ff;
      cnt_in        = cnt_ff;
      free_hit_in   = free_hit_ff;
      free_idx_in   = free_idx_ff;
      vic_hit_in    = vic_hit_ff;
      vic_idx_in    = vic_idx_ff;
      vic_age_in    = vic_age_ff;
      match_hit_in  = match_hit_ff;
      match_idx_in  = match_idx_ff;
      active_in     = active_ff;
      counts_in     = counts_ff;
      age_in        = age_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_voice_in  = rsp_voice_ff;
      rsp_stolen_in = rsp_stolen_ff;
      rsp_pcnt_in   = rsp_pcnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in        = opcode_type'(req_opcode);
               part_in      = req_part[PART_W-1:0];
               part_ok_in   = (req_part < REQ_PART_W'(NUM_PARTS));
               key_in       = req_note_key;
               plan_in      = plan_now;
               cnt_in       = '0;
               free_hit_in  = 1'b0;
               vic_hit_in   = 1'b0;
               match_hit_in = 1'b0;
               state_in     = part_ok_in ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            // track lowest free, oldest victim, lowest note-off match
            if (eval_en) begin
               if (op_ff == OP_NOTE_ON) begin
                  if (!eval_act && !free_hit_ff) begin
                     free_hit_in = 1'b1;
                     free_idx_in = eval_idx;
                  end
                  if (eval_act && (rd_entry_ff.part == plan_ff.target_part) &&
                      (!vic_hit_ff || (rd_entry_ff.age < vic_age_ff))) begin
                     vic_hit_in = 1'b1;
                     vic_idx_in = eval_idx;
                     vic_age_in = rd_entry_ff.age;
                  end
               end else if (eval_act && !match_hit_ff && (rd_entry_ff.part == part_ff) &&
                            (rd_entry_ff.key == key_ff)) begin
                  match_hit_in = 1'b1;
                  match_idx_in = eval_idx;
               end
            end
            if (cnt_ff == CNT_W'(NUM_VOICES)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FINISH: begin
            if (commit) begin
               if (take_free || take_vic) begin
                  active_in[wr_idx] = 1'b1;
                  if (take_vic) begin
                     counts_in[plan_ff.target_part] =
                        counts_in[plan_ff.target_part] - CNT_W'(1);
                  end
                  counts_in[part_ff] = counts_in[part_ff] + CNT_W'(1);
                  age_in = age_ff + AGE_W'(1);
               end
               if (take_off) begin
                  active_in[match_idx_ff] = 1'b0;
                  counts_in[part_ff]      = counts_ff[part_ff] - CNT_W'(1);
               end
               rsp_valid_in  = 1'b1;
               rsp_found_in  = take_free | take_vic | take_off;
               rsp_stolen_in = take_vic;
               if (take_free || take_vic) begin
                  rsp_voice_in = VOICE_W'(wr_idx);
               end else if (take_off) begin
                  rsp_voice_in = VOICE_W'(match_idx_ff);
               end else begin
                  rsp_voice_in = '0;
               end
               rsp_pcnt_in = part_ok_ff ? PCNT_W'(counts_in[part_ff]) : '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         counts_ff    <= '0;
         age_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         counts_ff    <= counts_in;
         age_ff       <= age_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      part_ff       <= part_in;
      part_ok_ff    <= part_ok_in;
      key_ff        <= key_in;
      plan_ff       <= plan_in;
      cnt_ff        <= cnt_in;
      free_hit_ff   <= free_hit_in;
      free_idx_ff   <= free_idx_in;
      vic_hit_ff    <= vic_hit_in;
      vic_idx_ff    <= vic_idx_in;
      vic_age_ff    <= vic_age_in;
      match_hit_ff  <= match_hit_in;
      match_idx_ff  <= match_idx_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_voice_ff  <= rsp_voice_in;
      rsp_stolen_ff <= rsp_stolen_in;
      rsp_pcnt_ff   <= rsp_pcnt_in;
   end

   // response outputs
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_voice      = rsp_voice_ff;
   assign rsp_stolen     = rsp_stolen_ff;
   assign rsp_part_count = rsp_pcnt_ff;

`ifndef ASSERT_OFF
   // a steal happens only when every voice is busy
   a_steal_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (commit && take_vic) |-> (&active_ff))
      else $error("voice stolen while a free voice exists");

   // a claimed voice is active after write-back
   a_claim_sets_active: assert property (@(posedge clock) disable iff (reset)
      (commit && (take_free || take_vic)) |=> active_ff[$past(wr_idx)])
      else $error("claimed voice not marked active");

   // a released voice is inactive after write-back
   a_release_clears_active: assert property (@(posedge clock) disable iff (reset)
      (commit && take_off) |=> !active_ff[$past(match_idx_ff)])
      else $error("released voice still active");

   // a victim from another part comes only from a part over its reservation
   a_other_part_over: assert property (@(posedge clock) disable iff (reset)
      (commit && take_vic && plan_ff.from_other) |->
         (CMP_W'(counts_ff[plan_ff.target_part]) > CMP_W'(res_ff[plan_ff.target_part])))
      else $error("voice stolen from a part within its reservation");

   // scan counter never runs past the table size
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff <= CNT_W'(NUM_VOICES)))
      else $error("scan counter past table end");
`endif

endmodule

// ===== verif/voice_allocator_reserved_stealing_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voice_allocator_reserved_stealing testbench
// Drives note on / note off beats through the request channel and checks
// every result beat, field by field, against a behavioral voice table kept
// here. A directed table covers the empty table, invalid parts, unmatched
// releases and each victim choice of voice stealing. Random phases then use
// several reservation settings, random idling on both channels and one long
// result back-pressure stretch.
// ----------------------------------------------------------------------------
module testbench
   import vas_pkg::*;
();

   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int LONG_HOLD       = 400;
   localparam int DRAIN_CYCLES    = 4 * (NUM_VOICES + 3);
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int PRESSURE_PHASE  = 2;

   typedef struct packed {
      logic               found;
      logic [VOICE_W-1:0] voice;
      logic               stolen;
      logic [PCNT_W-1:0]  part_count;
   } voice_result_type;

   typedef enum logic {
      ROW_NOTE,
      ROW_CONFIG
   } row_kind_type;

   // one line of directed stimulus
   typedef struct packed {
      row_kind_type         kind;
      opcode_type           op;
      logic [REQ_PART_W-1:0] part;
      logic [KEY_W-1:0]     key;
      logic [7:0]           reps;
      logic                 fixed;
      voice_result_type     fixed_result;
      res_vec_type          reserve;
   } stim_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_opcode = OP_NOTE_ON;
   logic [REQ_PART_W-1:0] req_part = '0;
   logic [KEY_W-1:0]      req_note_key = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_found;
   logic [VOICE_W-1:0]    rsp_voice;
   logic                  rsp_stolen;
   logic [PCNT_W-1:0]     rsp_part_count;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // behavioral copy of the voice table
   bit                    shadow_active [NUM_VOICES];
   bit [PART_W-1:0]       shadow_part [NUM_VOICES];
   bit [KEY_W-1:0]        shadow_key [NUM_VOICES];
   bit [AGE_W-1:0]        shadow_age [NUM_VOICES];
   bit [AGE_W-1:0]        age_serial = '0;
   res_vec_type           part_reserve = {NUM_REGS{RES_RESET}};

   voice_result_type      pending_results [$];
   int                    error_count = 0;
   bit                    allow_idle = 1'b1;
   bit                    hold_results = 1'b0;

   voice_allocator_reserved_stealing dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // active voices of one part
   function automatic int active_count(input int p);
      int n;
      n = 0;
      for (int i = 0; i < NUM_VOICES; i++)
         if (shadow_active[i] && shadow_part[i] == p) n++;
      return n;
   endfunction

   // oldest active voice of a part, lowest index on equal age, -1 if none
   function automatic int oldest_of(input int p);
      int best;
      best = -1;
      for (int i = 0; i < NUM_VOICES; i++)
         if (shadow_active[i] && shadow_part[i] == p &&
             (best < 0 || shadow_age[i] < shadow_age[best])) best = i;
      return best;
   endfunction

   // voice to steal when the table is full
   function automatic int pick_victim(input int p);
      int best_part;
      int top_excess;
      int held;
      best_part = -1;
      top_excess = 0;
      if (active_count(p) > int'(part_reserve[p])) return oldest_of(p);
      // other part most over its reservation, lowest part on a tie
      for (int q = 0; q < NUM_PARTS; q++) begin
         held = active_count(q);
         if (q != p && held > int'(part_reserve[q]) &&
             held - int'(part_reserve[q]) > top_excess) begin
            top_excess = held - int'(part_reserve[q]);
            best_part = q;
         end
      end
      if (best_part >= 0) return oldest_of(best_part);
      return oldest_of(p);
   endfunction

   // apply one note event to the voice table and return its result
   function automatic voice_result_type allocate_voice(input opcode_type op,
                                                       input logic [REQ_PART_W-1:0] p,
                                                       input logic [KEY_W-1:0] k);
      voice_result_type r;
      int slot;
      r = '0;
      slot = -1;
      if (p < NUM_PARTS) begin
         if (op == OP_NOTE_ON) begin
            for (int i = 0; i < NUM_VOICES; i++)
               if (!shadow_active[i] && slot < 0) slot = i;
            if (slot < 0) begin
               slot = pick_victim(int'(p));
               r.stolen = (slot >= 0);
            end
            if (slot >= 0) begin
               shadow_active[slot] = 1'b1;
               shadow_part[slot] = p[PART_W-1:0];
               shadow_key[slot] = k;
               shadow_age[slot] = age_serial;
               age_serial++;
            end
         end else begin
            for (int i = 0; i < NUM_VOICES; i++)
               if (slot < 0 && shadow_active[i] && shadow_part[i] == p &&
                   shadow_key[i] == k) slot = i;
            if (slot >= 0) shadow_active[slot] = 1'b0;
         end
         if (slot >= 0) begin
            r.found = 1'b1;
            r.voice = VOICE_W'(slot);
         end
         r.part_count = PCNT_W'(active_count(int'(p)));
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // offer one note beat, wait for it to be taken, record its result
   task automatic play_note(input opcode_type op, input logic [REQ_PART_W-1:0] p,
                            input logic [KEY_W-1:0] k, input bit fixed,
                            input voice_result_type fixed_result);
      voice_result_type predicted;
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_part <= p;
      req_note_key <= k;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = allocate_voice(op, p, k);
      pending_results.push_back(fixed ? fixed_result : predicted);
   endtask

   // random note beat, note on with the given percent weight; releases mostly aim at sounding notes
   task automatic random_note(input int on_weight);
      opcode_type op;
      logic [REQ_PART_W-1:0] p;
      logic [KEY_W-1:0] k;
      int pick;
      op = ($urandom_range(0, 99) < on_weight) ? OP_NOTE_ON : OP_NOTE_OFF;
      if ($urandom_range(0, 15) == 0) p = REQ_PART_W'($urandom_range(NUM_PARTS, 7));
      else p = REQ_PART_W'($urandom_range(0, NUM_PARTS - 1));
      case ($urandom_range(0, 3))
         0, 1: k = $urandom;
         2: k = KEY_W'($urandom_range(0, 3));
         default: k = ~KEY_W'($urandom_range(0, 3));
      endcase
      if (op == OP_NOTE_OFF && $urandom_range(0, 9) < 7) begin
         pick = $urandom_range(0, NUM_VOICES - 1);
         if (shadow_active[pick]) begin
            p = REQ_PART_W'(shadow_part[pick]);
            k = shadow_key[pick];
         end
      end
      play_note(op, p, k, 1'b0, '0);
   endtask

   // stop offering and wait until every result beat is back
   task automatic finish_pending();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // write all reservation registers, then read them back
   task automatic write_reservations(input res_vec_type values);
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= CSR_ADDR_W'(i << REG_SEL_LO);
         csr_pwdata <= ($urandom << RES_W) | CSR_DATA_W'(values[i]);
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         part_reserve[i] = values[i];
      end
      for (int i = 0; i < NUM_REGS; i++) begin
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         csr_paddr <= CSR_ADDR_W'(i << REG_SEL_LO);
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         check_field("reservation readback", CSR_DATA_W'(values[i]), csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic stim_row_type note_row(input opcode_type op,
                                             input logic [REQ_PART_W-1:0] p,
                                             input logic [KEY_W-1:0] k, input int reps);
      stim_row_type row;
      row = '0;
      row.kind = ROW_NOTE;
      row.op = op;
      row.part = p;
      row.key = k;
      row.reps = 8'(reps);
      return row;
   endfunction

   function automatic stim_row_type fixed_row(input opcode_type op,
                                              input logic [REQ_PART_W-1:0] p,
                                              input logic [KEY_W-1:0] k,
                                              input int found, input int voice,
                                              input int stolen, input int count);
      stim_row_type row;
      row = note_row(op, p, k, 1);
      row.fixed = 1'b1;
      row.fixed_result = '{found: 1'(found), voice: VOICE_W'(voice),
                           stolen: 1'(stolen), part_count: PCNT_W'(count)};
      return row;
   endfunction

   function automatic stim_row_type config_row(input int r0, input int r1,
                                               input int r2, input int r3);
      stim_row_type row;
      row = '0;
      row.kind = ROW_CONFIG;
      row.reserve = {RES_W'(r3), RES_W'(r2), RES_W'(r1), RES_W'(r0)};
      return row;
   endfunction

   // result beat checker
   always @(posedge clock) begin : rsp_monitor
      voice_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with none expected, found %0h voice %0d",
                     $time, rsp_found, rsp_voice);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("found", 32'(want.found), 32'(rsp_found));
            check_field("voice", 32'(want.voice), 32'(rsp_voice));
            check_field("stolen", 32'(want.stolen), 32'(rsp_stolen));
            check_field("part_count", 32'(want.part_count), 32'(rsp_part_count));
         end
      end
   end

   // result side ready, in random bursts, with one long hold-off on request
   initial begin : rsp_pacing
      forever begin
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (allow_idle && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   end

   // watchdog on cycles without any beat or register access
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) quiet = 0;
         else quiet++;
      end
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench: FAIL");
      $finish;
   end

   initial begin : stimulus
      stim_row_type directed_rows [$];
      res_vec_type reserve;
      directed_rows = '{
         // empty table, invalid parts, unmatched release
         fixed_row(OP_NOTE_OFF, 3'd0, 32'h0000_0000, 0, 0, 0, 0),
         fixed_row(OP_NOTE_ON,  3'd4, 32'h0000_1234, 0, 0, 0, 0),
         fixed_row(OP_NOTE_OFF, 3'd7, 32'hFFFF_FFFF, 0, 0, 0, 0),
         fixed_row(OP_NOTE_ON,  3'd0, 32'hFFFF_FFFF, 1, 0, 0, 1),
         fixed_row(OP_NOTE_OFF, 3'd0, 32'h0000_0000, 0, 0, 0, 1),
         // fill the table: part 0 ten voices, part 1 eight, part 2 six
         note_row(OP_NOTE_ON, 3'd0, 32'h0000_0010, 9),
         note_row(OP_NOTE_ON, 3'd1, 32'h0000_0020, 8),
         note_row(OP_NOTE_ON, 3'd2, 32'h0000_0030, 6),
         // own part over reservation steals its own oldest
         note_row(OP_NOTE_ON, 3'd0, 32'h0000_0040, 1),
         // part within reservation steals from the part most over
         note_row(OP_NOTE_ON, 3'd3, 32'h0000_00A0, 1),
         // parts 0 and 1 tie on excess, lower part loses a voice
         config_row(8, 7, 6, 31),
         note_row(OP_NOTE_ON, 3'd3, 32'h0000_00B0, 1),
         // nobody over reservation, fall back to own oldest
         config_row(31, 31, 31, 31),
         note_row(OP_NOTE_ON, 3'd1, 32'h0000_00C0, 1),
         note_row(OP_NOTE_OFF, 3'd3, 32'h0000_00A0, 1),
         note_row(OP_NOTE_OFF, 3'd3, 32'h0000_00B0, 1),
         note_row(OP_NOTE_ON, 3'd2, 32'h0000_00D0, 2),
         // full table, part holds nothing and nobody is over: no voice
         fixed_row(OP_NOTE_ON, 3'd3, 32'h0000_00E0, 0, 0, 0, 0),
         // zero reservations, three-way tie on excess
         config_row(0, 0, 0, 0),
         note_row(OP_NOTE_ON, 3'd3, 32'h0000_00F0, 1),
         note_row(OP_NOTE_OFF, 3'd1, 32'h0000_0021, 1)
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows
      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == ROW_CONFIG) begin
            finish_pending();
            write_reservations(directed_rows[n].reserve);
         end else begin
            for (int j = 0; j < int'(directed_rows[n].reps); j++)
               play_note(directed_rows[n].op, directed_rows[n].part,
                         directed_rows[n].key + KEY_W'(j), directed_rows[n].fixed,
                         directed_rows[n].fixed_result);
         end
      end

      // random phases, each under its own reservations
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         finish_pending();
         for (int i = 0; i < NUM_REGS; i++)
            case (phase)
               1: reserve[i] = '1;
               3: reserve[i] = '0;
               2, 5: reserve[i] = RES_W'($urandom_range(0, 6));
               default: reserve[i] = RES_W'($urandom_range(0, 31));
            endcase
         write_reservations(reserve);
         allow_idle = (phase != RANDOM_PHASES - 1);
         if (phase == PRESSURE_PHASE) hold_results = 1'b1;
         repeat (ITEMS_PER_PHASE) random_note(50 + 6 * phase);
      end

      finish_pending();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
